/* rtl/tdq_pkg.sv */
package tdq_pkg;

    // Width of the saturated voltage outputs.
    localparam int DATA_WIDTH = 32;

    // Restoring division steps (48-bit dividend) and square root steps (31-bit root).
    localparam int DIV_STEPS  = 48;
    localparam int SQRT_STEPS = 31;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_STALL     = 3'd0;
    localparam logic [2:0] REG_KT        = 3'd1;
    localparam logic [2:0] REG_POLES     = 3'd2;
    localparam logic [2:0] REG_IND       = 3'd3;
    localparam logic [2:0] REG_RES       = 3'd4;
    localparam logic [2:0] REG_RL_ON     = 3'd5;
    localparam logic [2:0] REG_BEMF_ON   = 3'd6;
    localparam logic [2:0] REG_GIMBAL    = 3'd7;

    // floor(y / 25) = (y * RECIP25) >> 35 for y below 2^30.
    localparam logic [30:0] RECIP25      = 31'd1374389535;
    // 2^24 = 3 * SPLIT3 + 1, used to divide a 48-bit value by three.
    localparam logic [22:0] SPLIT3       = 23'd5592405;
    // floor(w / 3) = (w * RECIP3) >> 27 for w below 2^25.
    localparam logic [25:0] RECIP3       = 26'd44739243;

    // Data handed from cell to cell: division, square root and the item's payload.
    typedef struct packed {
        logic [30:0] rem;
        logic [47:0] nq;
        logic [32:0] srem;
        logic [61:0] rad;
        logic [30:0] root;
        logic        tor_neg;
        logic [31:0] vel_m;
        logic        vel_neg;
        logic [31:0] id;
        logic [30:0] id_m;
    } cell_t;

endpackage

/* rtl/tdq_cell.sv */
module tdq_cell
    import tdq_pkg::*;
#(
    parameter bit DO_SQRT = 1'b1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [30:0] divisor,
    input  logic        src_valid,
    input  cell_t       src,
    output logic        dst_valid,
    output cell_t       dst
);

    cell_t       dst_reg;
    cell_t       dst_next;
    logic        dst_valid_reg;
    logic [31:0] cur;
    logic [34:0] scur;
    logic [34:0] trial;

    // One restoring division step and, where enabled, one square root step.
    always_comb
    begin
        dst_next = src;
        cur      = {src.rem, src.nq[47]};
        scur     = {src.srem, src.rad[61:60]};
        trial    = {2'b00, src.root, 2'b01};
        if (cur >= {1'b0, divisor})
        begin
            dst_next.rem = 31'(cur - {1'b0, divisor});
            dst_next.nq  = {src.nq[46:0], 1'b1};
        end
        else
        begin
            dst_next.rem = cur[30:0];
            dst_next.nq  = {src.nq[46:0], 1'b0};
        end
        if (DO_SQRT)
        begin
            dst_next.rad = {src.rad[59:0], 2'b00};
            if (scur >= trial)
            begin
                dst_next.srem = 33'(scur - trial);
                dst_next.root = {src.root[29:0], 1'b1};
            end
            else
            begin
                dst_next.srem = scur[32:0];
                dst_next.root = {src.root[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dst_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dst_reg <= dst_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst       = dst_reg;

endmodule

/* rtl/torque_to_dq_voltage_feedforward.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_ready    | torque_request, d_current_request, mech_velocity
// output   | out_valid / out_ready  | d_voltage, q_voltage, d_current_target,
//          |                        | q_current_target, currents_updated, q_current_limited
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item enters per cycle, but none while the pipeline holds.
// Items pass through a row of 48 division cells (31 also do a square root step).
// The whole pipeline moves together and holds while a finished result is not taken.
// Reset clears all valid bits and loads the register defaults; cfg_ready is always high.
module torque_to_dq_voltage_feedforward
    import tdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] torque_request,
    input  logic [31:0] d_current_request,
    input  logic [31:0] mech_velocity,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] d_voltage,
    output logic [31:0] q_voltage,
    output logic [31:0] d_current_target,
    output logic [31:0] q_current_target,
    output logic        currents_updated,
    output logic        q_current_limited,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef struct packed {
        logic [31:0] tor_m;
        logic        tor_neg;
        logic [31:0] vel_m;
        logic        vel_neg;
        logic [31:0] idr;
        logic [60:0] prod;
        logic [30:0] id_lim;
        logic [31:0] id;
        logic [30:0] id_m;
        logic [61:0] s2;
        logic [61:0] d2;
    } pre_t;

    typedef struct packed {
        logic [31:0] id;
        logic [30:0] id_m;
        logic        vel_neg;
        logic        tor_neg;
        logic [30:0] iq_m;
        logic [31:0] iq;
        logic        limited;
        logic [31:0] wv;
        logic [47:0] bb;
        logic [38:0] wl;
        logic [45:0] r_id;
        logic [45:0] r_iq;
        logic [46:0] hp;
        logic [24:0] w;
        logic [53:0] wiq_a;
        logic [30:0] wiq_b;
        logic [53:0] wid_a;
        logic [30:0] wid_b;
        logic [47:0] bemf;
        logic [54:0] wl_iq;
        logic [54:0] wl_id;
        logic signed [57:0] vd;
        logic signed [57:0] vq;
    } post_t;

    localparam logic signed [57:0] SAT_HI = (58'sd1 <<< (DATA_WIDTH - 1)) - 58'sd1;
    localparam logic signed [57:0] SAT_LO = -SAT_HI - 58'sd1;

    function automatic logic signed [57:0] with_sign(input logic [54:0] m, input logic neg);
        logic signed [57:0] v;
        v = $signed({3'b000, m});
        return neg ? -v : v;
    endfunction

    // Configuration registers.
    logic [30:0] stall_reg;
    logic [30:0] kt_reg;
    logic [6:0]  poles_reg;
    logic [31:0] ind_reg;
    logic [30:0] res_reg;
    logic        rl_on_reg;
    logic        bemf_on_reg;
    logic        gimbal_reg;
    logic [30:0] kt_div;

    logic        adv;
    pre_t        pre_reg [1:4];
    pre_t        pre_next [1:4];
    logic [4:1]  pre_v_reg;
    cell_t       c0_reg;
    cell_t       c0_next;
    logic        c0_v_reg;
    cell_t       chain [0:DIV_STEPS];
    logic        chain_v [0:DIV_STEPS];
    post_t       post_reg [1:5];
    post_t       post_next [1:5];
    logic [5:1]  post_v_reg;
    logic        out_valid_reg;
    logic [31:0] vd_reg;
    logic [31:0] vq_reg;
    logic [31:0] id_out_reg;
    logic [31:0] iq_out_reg;
    logic        upd_reg;
    logic        lim_reg;
    logic [31:0] y_sum;
    logic [32:0] idr_w;
    logic [32:0] lim_w;
    logic [63:0] mv;
    logic [62:0] mb;
    logic [61:0] pr_id;
    logic [61:0] pr_iq;
    logic [46:0] tq;
    logic [46:0] td;
    logic [50:0] pw;
    logic [31:0] vd_sat;
    logic [31:0] vq_sat;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign kt_div    = (kt_reg == 31'd0) ? 31'd1 : kt_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_reg   <= 31'd655360;
            kt_reg      <= 31'd2621;
            poles_reg   <= 7'd7;
            ind_reg     <= 32'd429497;
            res_reg     <= 31'd6554;
            rl_on_reg   <= 1'b0;
            bemf_on_reg <= 1'b0;
            gimbal_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STALL:   stall_reg   <= cfg_data[30:0];
                REG_KT:      kt_reg      <= cfg_data[30:0];
                REG_POLES:   poles_reg   <= cfg_data[6:0];
                REG_IND:     ind_reg     <= cfg_data;
                REG_RES:     res_reg     <= cfg_data[30:0];
                REG_RL_ON:   rl_on_reg   <= cfg_data[0];
                REG_BEMF_ON: bemf_on_reg <= cfg_data[0];
                REG_GIMBAL:  gimbal_reg  <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Front stages: magnitudes, d-current limit, clamp, squares and radicand.
    always_comb
    begin
        y_sum               = 32'(stall_reg) + 32'd99;
        pre_next[1]         = '0;
        pre_next[1].tor_neg = torque_request[31];
        pre_next[1].tor_m   = torque_request[31] ? -torque_request : torque_request;
        pre_next[1].vel_neg = mech_velocity[31];
        pre_next[1].vel_m   = mech_velocity[31] ? -mech_velocity : mech_velocity;
        pre_next[1].idr     = d_current_request;
        pre_next[1].prod    = 61'(y_sum[31:2]) * 61'(RECIP25);

        pre_next[2]         = pre_reg[1];
        pre_next[2].id_lim  = stall_reg - {5'b0, pre_reg[1].prod[60:35]};

        pre_next[3]         = pre_reg[2];
        idr_w               = {pre_reg[2].idr[31], pre_reg[2].idr};
        lim_w               = {2'b00, pre_reg[2].id_lim};
        if ($signed(idr_w) > $signed(lim_w))
        begin
            pre_next[3].id = {1'b0, pre_reg[2].id_lim};
        end
        else if ($signed(idr_w) < -$signed(lim_w))
        begin
            pre_next[3].id = -{1'b0, pre_reg[2].id_lim};
        end
        else
        begin
            pre_next[3].id = pre_reg[2].idr;
        end
        pre_next[3].id_m    = pre_next[3].id[31] ? 31'(-pre_next[3].id)
                                                 : pre_next[3].id[30:0];

        pre_next[4]         = pre_reg[3];
        pre_next[4].s2      = 62'(stall_reg) * 62'(stall_reg);
        pre_next[4].d2      = 62'(pre_reg[3].id_m) * 62'(pre_reg[3].id_m);

        c0_next             = '0;
        c0_next.nq          = {pre_reg[4].tor_m, 16'b0};
        c0_next.rad         = (pre_reg[4].s2 > pre_reg[4].d2) ?
                              (pre_reg[4].s2 - pre_reg[4].d2) : 62'd0;
        c0_next.tor_neg     = pre_reg[4].tor_neg;
        c0_next.vel_m       = pre_reg[4].vel_m;
        c0_next.vel_neg     = pre_reg[4].vel_neg;
        c0_next.id          = pre_reg[4].id;
        c0_next.id_m        = pre_reg[4].id_m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg     <= '0;
            c0_v_reg      <= 1'b0;
            post_v_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pre_v_reg     <= {pre_v_reg[3:1], in_valid};
            c0_v_reg      <= pre_v_reg[4];
            post_v_reg    <= {post_v_reg[4:1], chain_v[DIV_STEPS]};
            out_valid_reg <= post_v_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_reg[1]  <= pre_next[1];
            pre_reg[2]  <= pre_next[2];
            pre_reg[3]  <= pre_next[3];
            pre_reg[4]  <= pre_next[4];
            c0_reg      <= c0_next;
            post_reg[1] <= post_next[1];
            post_reg[2] <= post_next[2];
            post_reg[3] <= post_next[3];
            post_reg[4] <= post_next[4];
            post_reg[5] <= post_next[5];
            vd_reg      <= vd_sat;
            vq_reg      <= vq_sat;
            id_out_reg  <= post_reg[5].id;
            iq_out_reg  <= post_reg[5].iq;
            upd_reg     <= !gimbal_reg;
            lim_reg     <= post_reg[5].limited;
        end
    end

    // Row of division and square root cells.
    assign chain[0]   = c0_reg;
    assign chain_v[0] = c0_v_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_cell
        tdq_cell #(
            .DO_SQRT (k < SQRT_STEPS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .divisor   (kt_div),
            .src_valid (chain_v[k]),
            .src       (chain[k]),
            .dst_valid (chain_v[k + 1]),
            .dst       (chain[k + 1])
        );
    end

    // Back stages: current limit, feedforward products and sums.
    always_comb
    begin
        post_next[1]         = '0;
        post_next[1].id      = chain[DIV_STEPS].id;
        post_next[1].id_m    = chain[DIV_STEPS].id_m;
        post_next[1].vel_neg = chain[DIV_STEPS].vel_neg;
        post_next[1].tor_neg = chain[DIV_STEPS].tor_neg;
        post_next[1].limited = chain[DIV_STEPS].nq > {17'b0, chain[DIV_STEPS].root};
        post_next[1].iq_m    = post_next[1].limited ? chain[DIV_STEPS].root
                                                    : chain[DIV_STEPS].nq[30:0];
        mv                   = 64'(chain[DIV_STEPS].vel_m) * 64'(ind_reg);
        post_next[1].wv      = mv[63:32];
        mb                   = 63'(chain[DIV_STEPS].vel_m) * 63'(kt_reg);
        post_next[1].bb      = mb[62:15];

        post_next[2]         = post_reg[1];
        post_next[2].iq      = post_reg[1].tor_neg ? -{1'b0, post_reg[1].iq_m}
                                                   : {1'b0, post_reg[1].iq_m};
        post_next[2].wl      = 39'(post_reg[1].wv) * 39'(poles_reg);
        pr_id                = 62'(res_reg) * 62'(post_reg[1].id_m);
        pr_iq                = 62'(res_reg) * 62'(post_reg[1].iq_m);
        post_next[2].r_id    = pr_id[61:16];
        post_next[2].r_iq    = pr_iq[61:16];
        post_next[2].hp      = 47'(post_reg[1].bb[47:24]) * 47'(SPLIT3);
        post_next[2].w       = 25'(post_reg[1].bb[47:24]) + 25'(post_reg[1].bb[23:0]);

        post_next[3]         = post_reg[2];
        post_next[3].wiq_a   = 54'(post_reg[2].wl[38:16]) * 54'(post_reg[2].iq_m);
        tq                   = 47'(post_reg[2].wl[15:0]) * 47'(post_reg[2].iq_m);
        post_next[3].wiq_b   = tq[46:16];
        post_next[3].wid_a   = 54'(post_reg[2].wl[38:16]) * 54'(post_reg[2].id_m);
        td                   = 47'(post_reg[2].wl[15:0]) * 47'(post_reg[2].id_m);
        post_next[3].wid_b   = td[46:16];
        pw                   = 51'(post_reg[2].w) * 51'(RECIP3);
        post_next[3].bemf    = 48'(post_reg[2].hp) + 48'(pw[50:27]);

        post_next[4]         = post_reg[3];
        post_next[4].wl_iq   = 55'(post_reg[3].wiq_a) + 55'(post_reg[3].wiq_b);
        post_next[4].wl_id   = 55'(post_reg[3].wid_a) + 55'(post_reg[3].wid_b);

        post_next[5]         = post_reg[4];
        post_next[5].vd      = 58'sd0;
        post_next[5].vq      = 58'sd0;
        if (rl_on_reg)
        begin
            post_next[5].vd = with_sign(55'(post_reg[4].r_id), post_reg[4].id[31])
                            - with_sign(post_reg[4].wl_iq,
                                        post_reg[4].vel_neg != post_reg[4].tor_neg);
            post_next[5].vq = with_sign(post_reg[4].wl_id,
                                        post_reg[4].vel_neg != post_reg[4].id[31])
                            + with_sign(55'(post_reg[4].r_iq), post_reg[4].tor_neg);
        end
        if (bemf_on_reg && (poles_reg != 7'd0))
        begin
            post_next[5].vq = post_next[5].vq
                            + with_sign(55'(post_reg[4].bemf), post_reg[4].vel_neg);
        end
        if (gimbal_reg)
        begin
            post_next[5].vd = post_next[5].vd + 58'($signed(post_reg[4].id));
            post_next[5].vq = post_next[5].vq + 58'($signed(post_reg[4].iq));
        end
    end

    // Saturation into the output register.
    always_comb
    begin
        if (post_reg[5].vd > SAT_HI)
        begin
            vd_sat = 32'(SAT_HI);
        end
        else if (post_reg[5].vd < SAT_LO)
        begin
            vd_sat = 32'(SAT_LO);
        end
        else
        begin
            vd_sat = post_reg[5].vd[31:0];
        end
        if (post_reg[5].vq > SAT_HI)
        begin
            vq_sat = 32'(SAT_HI);
        end
        else if (post_reg[5].vq < SAT_LO)
        begin
            vq_sat = 32'(SAT_LO);
        end
        else
        begin
            vq_sat = post_reg[5].vq[31:0];
        end
    end

    assign out_valid         = out_valid_reg;
    assign d_voltage         = vd_reg;
    assign q_voltage         = vq_reg;
    assign d_current_target  = id_out_reg;
    assign q_current_target  = iq_out_reg;
    assign currents_updated  = upd_reg;
    assign q_current_limited = lim_reg;

endmodule

/* rtl/tdq_checker.sv */
module tdq_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] torque_request,
    input  logic [31:0] d_current_request,
    input  logic [31:0] mech_velocity,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] d_voltage,
    input  logic [31:0] q_voltage,
    input  logic [31:0] d_current_target,
    input  logic [31:0] q_current_target,
    input  logic        currents_updated,
    input  logic        q_current_limited,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(d_voltage) && $stable(q_voltage))
        else $error("output result changed while stalled");

    // The pipeline takes input exactly when its output stage can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stage");

    // Register writes are never held off.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transfer stalled");

    // Clamped currents never reach the most negative code.
    a_cur: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (d_current_target != 32'h8000_0000)
                   && (q_current_target != 32'h8000_0000))
        else $error("current target out of range");

endmodule

bind torque_to_dq_voltage_feedforward tdq_checker u_tdq_checker (.*);
